FILE: hdl/pump_session_supervisor_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pump session supervisor
// Concurrent checks clocked on clk; the RST form also covers the reset window.
// ----------------------------------------------------------------------------
`ifndef PUMP_SESSION_SUPERVISOR_TOP_MACROS_SVH
`define PUMP_SESSION_SUPERVISOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that is suspended while reset is asserted
`define PSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted
`define PSS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PSS_ASSERT(label, prop, msg)
`define PSS_ASSERT_RST(label, prop, msg)

`endif

`endif

FILE: hdl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and codes for the pump session supervisor.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int unsigned PRES_W  = 13;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned ACC_W   = 20;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IN_W    = 32;
    localparam int unsigned OUT_W   = 128;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Item opcodes
    localparam logic [1:0] OP_PRESSURE = 2'd0;
    localparam logic [1:0] OP_TIME     = 2'd1;
    localparam logic [1:0] OP_BUTTON   = 2'd2;

    // Button codes
    localparam logic [1:0] BTN_A = 2'd1;
    localparam logic [1:0] BTN_B = 2'd2;

    // Operating modes
    localparam logic [1:0] MODE_MANUAL     = 2'd0;
    localparam logic [1:0] MODE_HYSTERESIS = 2'd1;
    localparam logic [1:0] MODE_ADAPTIVE   = 2'd2;

    // Limit report codes
    localparam logic [1:0] LIMIT_NONE    = 2'd0;
    localparam logic [1:0] LIMIT_PUMPING = 2'd1;
    localparam logic [1:0] LIMIT_SESSION = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_SESSION   = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_PUMPING   = 3'd2;
    localparam logic [IDX_W-1:0] REG_PUMP_REMOTE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_VALVE_REMOTE  = 3'd4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] max_session_secs;
        logic [CNT_W-1:0] max_pumping_secs;
        logic             pump_remote_off;
        logic             valve_remote_off;
    } pss_cfg_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [PRES_W-1:0] pressure_hpa;
        logic [CNT_W-1:0]        elapsed_ms;
        logic [1:0]              button_code;
    } pss_item_t;

    typedef struct packed {
        logic                     pump_state;
        logic                     valve_state;
        logic                     held_off_flag;
        logic signed [PRES_W-1:0] cur_pressure;
        logic signed [PRES_W-1:0] min_pressure;
        logic signed [PRES_W-1:0] max_pressure;
        logic [ACC_W-1:0]         ms_accumulator;
        logic [CNT_W-1:0]         session_count;
        logic [CNT_W-1:0]         pumping_count;
        logic [CNT_W-1:0]         last_session_count;
        logic [TOTAL_W-1:0]       total_count;
    } pss_state_t;

endpackage

FILE: hdl/pss_cfg_regs.sv
// ----------------------------------------------------------------------------
// pss_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module pss_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [pss_pkg::IDX_W-1:0]  wr_index,
    input  logic [pss_pkg::CFG_W-1:0]  wr_data,
    output pss_pkg::pss_cfg_t          cfg
);
    import pss_pkg::*;

    pss_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= MODE_MANUAL;
            cfg_reg.max_session_secs <= 16'd1800;
            cfg_reg.max_pumping_secs <= 16'd600;
            cfg_reg.pump_remote_off  <= 1'b0;
            cfg_reg.valve_remote_off <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MODE:         cfg_reg.mode             <= wr_data[1:0];
                REG_MAX_SESSION:  cfg_reg.max_session_secs <= wr_data;
                REG_MAX_PUMPING:  cfg_reg.max_pumping_secs <= wr_data;
                REG_PUMP_REMOTE:  cfg_reg.pump_remote_off  <= wr_data[0];
                REG_VALVE_REMOTE: cfg_reg.valve_remote_off <= wr_data[0];
                default:          ; // drop writes to unmapped indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/pss_step.sv
// ----------------------------------------------------------------------------
// pss_step
// Next-state logic for one item: pressure window, time base, buttons.
// ----------------------------------------------------------------------------
module pss_step #(
    parameter int unsigned MS_PER_SECOND = 1000
) (
    input  pss_pkg::pss_cfg_t   cfg,
    input  pss_pkg::pss_item_t  item,
    input  pss_pkg::pss_state_t state,
    output pss_pkg::pss_state_t state_next,
    output logic [1:0]          limit_hit
);
    import pss_pkg::*;

    localparam logic [ACC_W-1:0] MS_ACC = ACC_W'(MS_PER_SECOND);

    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] acc_sat;
    logic [CNT_W-1:0] sess_inc;
    logic [CNT_W-1:0] pump_inc;
    logic             active;
    logic             remote_active;

    always_comb
    begin
        state_next = state;
        limit_hit  = LIMIT_NONE;
        active     = state.pump_state | state.valve_state;

        acc_sum  = {1'b0, state.ms_accumulator} + {{(ACC_W + 1 - CNT_W){1'b0}}, item.elapsed_ms};
        acc_sat  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        sess_inc = (state.session_count != CNT_MAX) ? state.session_count + 1'b1
                                                    : state.session_count;
        pump_inc = (state.pump_state && state.pumping_count != CNT_MAX)
                 ? state.pumping_count + 1'b1 : state.pumping_count;

        remote_active = (cfg.mode == MODE_HYSTERESIS || cfg.mode == MODE_ADAPTIVE)
                      ? !state.held_off_flag : state.pump_state;

        case (item.opcode)
            OP_PRESSURE:
            begin
                state_next.cur_pressure = item.pressure_hpa;
                if (!active)
                begin
                    state_next.min_pressure = item.pressure_hpa;
                    state_next.max_pressure = item.pressure_hpa;
                end
                else
                begin
                    if (item.pressure_hpa < state.min_pressure)
                        state_next.min_pressure = item.pressure_hpa;
                    if (item.pressure_hpa > state.max_pressure)
                        state_next.max_pressure = item.pressure_hpa;
                end
            end
            OP_TIME:
            begin
                state_next.ms_accumulator = acc_sat;
                if (acc_sat >= MS_ACC)
                begin
                    state_next.ms_accumulator = acc_sat - MS_ACC;
                    if (!active)
                    begin
                        // idle second: roll a finished session over
                        if (state.session_count != '0)
                        begin
                            state_next.last_session_count = state.session_count;
                            state_next.session_count      = '0;
                            state_next.pumping_count      = '0;
                        end
                    end
                    else
                    begin
                        state_next.session_count = sess_inc;
                        state_next.pumping_count = pump_inc;
                        state_next.total_count   = state.total_count + 1'b1;
                        if (sess_inc >= cfg.max_session_secs)
                        begin
                            state_next.pump_state  = 1'b0;
                            state_next.valve_state = 1'b0;
                            limit_hit              = LIMIT_SESSION;
                        end
                        else if (pump_inc >= cfg.max_pumping_secs)
                        begin
                            state_next.pump_state = 1'b0;
                            limit_hit             = LIMIT_PUMPING;
                        end
                    end
                end
            end
            OP_BUTTON:
            begin
                if (item.button_code == BTN_A && !cfg.pump_remote_off)
                begin
                    if (remote_active)
                    begin
                        state_next.pump_state    = 1'b0;
                        state_next.held_off_flag = 1'b1;
                    end
                    else
                    begin
                        if (cfg.mode == MODE_MANUAL)
                            state_next.valve_state = 1'b1;
                        state_next.pump_state    = 1'b1;
                        state_next.held_off_flag = 1'b0;
                    end
                end
                else if (item.button_code == BTN_B && !cfg.valve_remote_off)
                begin
                    state_next.valve_state = !state.valve_state;
                end
            end
            default: ; // unused opcode leaves the state alone
        endcase
    end

endmodule

FILE: hdl/pump_session_supervisor_top.sv
// ----------------------------------------------------------------------------
// pump_session_supervisor_top
// Vacuum pump and valve supervisor: pressure window, session timing, buttons.
// Path: input transfer into the input register, then the step logic, then the result register.
// Throughput: one item per cycle while the result stream is not stalled; the state
// update is the single combinational step between the input and result registers.
// Reset: rst_n async, active low; clears both stage valid flags, all session state, and
// loads the register defaults (mode 0, session 1800 s, pumping 600 s).
// ----------------------------------------------------------------------------
`include "pump_session_supervisor_top_macros.svh"

module pump_session_supervisor_top #(
    parameter int unsigned MS_PER_SECOND = 1000
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // [1:0] opcode
    input  logic [31:0]  s_tdata,   // [12:0] pressure_hpa, [28:13] elapsed_ms,
                                    // [30:29] button_code, [31] zero
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [0] pump_on, [1] valve_on, [2] pump_held_off,
                                    // [15:3] now_pressure, [28:16] low_pressure,
                                    // [41:29] high_pressure, [57:42] session_secs,
                                    // [73:58] pumping_secs,
                                    // [89:74] previous_session_secs,
                                    // [121:90] lifetime_secs, [123:122] limit_hit,
                                    // [127:124] zero
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import pss_pkg::*;

    pss_cfg_t   cfg;
    pss_item_t  item_reg;
    logic       item_valid_reg;
    pss_state_t state_reg;
    pss_state_t state_next;
    logic [1:0] limit_next;
    logic       out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;
    logic       advance;
    logic       take_in;

    // Registers are always writable; the sender issues writes only while no item is in
    // flight. The sender is bound to this; the block itself does not enforce it.
    assign cfg_ready = 1'b1;

    pss_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Result register frees up when empty or when its transfer completes.
    assign advance  = !out_valid_reg || m_tready;
    // Input register takes a new item when empty or when its current one moves on.
    assign s_tready = !item_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    // Input register: hold the item until the step logic consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (s_tready)
            item_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.opcode       <= s_tuser;
            item_reg.pressure_hpa <= s_tdata[12:0];
            item_reg.elapsed_ms   <= s_tdata[28:13];
            item_reg.button_code  <= s_tdata[30:29];
        end
    end

    pss_step #(
        .MS_PER_SECOND (MS_PER_SECOND)
    ) u_step (
        .cfg        (cfg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .limit_hit  (limit_next)
    );

    // Supervisor state: advance only when an item actually moves into the result reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (item_valid_reg && advance)
            state_reg <= state_next;
    end

    // Pack the result fields, lowest bit first
    assign out_data_next = {4'b0000,
                            limit_next,
                            state_next.total_count,
                            state_next.last_session_count,
                            state_next.pumping_count,
                            state_next.session_count,
                            state_next.max_pressure,
                            state_next.min_pressure,
                            state_next.cur_pressure,
                            state_next.held_off_flag,
                            state_next.valve_state,
                            state_next.pump_state};

    // Result register: hold until the downstream transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `PSS_ASSERT_RST(a_reset_empty, !rst_n |=> (!m_tvalid && !item_valid_reg), "result valid during reset")
    `PSS_ASSERT(a_item_reaches_out, (item_valid_reg && advance) |=> m_tvalid, "item lost between stages")
    `PSS_ASSERT(a_pump_within_session, state_reg.pumping_count <= state_reg.session_count, "pumping count above session count")
    `PSS_ASSERT(a_limit_code, m_tvalid |-> (m_tdata[123:122] != 2'd3), "illegal limit code")
    `PSS_ASSERT(a_shutdown_off, (m_tvalid && m_tdata[123:122] == LIMIT_SESSION) |-> (!m_tdata[0] && !m_tdata[1]), "outputs on after session shutdown")

endmodule
